@@ rtl/dseu_pkg.sv @@
// Shared constants, types and codes for the disjoint-set edge union block.
// No dependencies; every other file of the block imports this package.
package dseu_pkg;

	localparam int MAX_NODES = 1024;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = IDX_W + 1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_FIND_INIT,
		ST_FIND,
		ST_COMP_INIT,
		ST_COMP,
		ST_LINK,
		ST_FINISH
	} dseu_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_FIND_INIT,
		OP_FIND_STEP,
		OP_COMP_INIT,
		OP_COMP_STEP,
		OP_LINK,
		OP_RESULT
	} dseu_op_t;

	typedef struct packed {
		dseu_op_t op;
		logic     phase_b;
	} dseu_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic rd_is_root;
		logic start_is_root;
		logic roots_differ;
	} dseu_sts_t;

endpackage

@@ rtl/dseu_intf.sv @@
// Valid/ready channel interfaces for edge words in and result words out.
// Depends on dseu_pkg for the index and count widths.
interface dseu_edge_if;
	import dseu_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] node_a;
	logic [IDX_W-1:0] node_b;

	modport source (output valid, output node_a, output node_b, input ready);
	modport sink (input valid, input node_a, input node_b, output ready);
endinterface

interface dseu_result_if;
	import dseu_pkg::*;

	logic             valid;
	logic             ready;
	logic             merged;
	logic [IDX_W-1:0] root_first;
	logic [IDX_W-1:0] root_second;
	logic [CNT_W-1:0] sets_remaining;
	logic             all_joined;
	logic             bad_index;

	modport source (
		output valid, output merged, output root_first, output root_second,
		output sets_remaining, output all_joined, output bad_index, input ready
	);
	modport sink (
		input valid, input merged, input root_first, input root_second,
		input sets_remaining, input all_joined, input bad_index, output ready
	);
endinterface

@@ rtl/disjoint_set_edge_union.sv @@
// Top level of the disjoint-set edge union block: controller plus datapath.
// Depends on dseu_pkg, dseu_intf, dseu_ctrl and dseu_dp.

// Union-find over up to 1024 nodes with full path compression. Each edge word
// (node_a, node_b) yields one result word. After reset and after every write of
// the node count, a clearing pass resets the parent memory and no edge is taken
// meanwhile. An edge with an index at or above the node count skips both walks
// and the link. A valid edge walks from each endpoint to its root, then walks that
// path again to point every node on it at the root; the parent memory has one
// registered read port, so each walk follows one parent link at a time. The result
// register lets the next edge start while a result still waits to be taken.
module disjoint_set_edge_union (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dseu_pkg::CNT_W-1:0] cfg_wdata,
	dseu_edge_if.sink                  edges,
	dseu_result_if.source              results
);
	import dseu_pkg::*;

	dseu_cmd_t cmd;
	dseu_sts_t sts;

	dseu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (edges.valid),
		.in_ready  (edges.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dseu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.node_a         (edges.node_a),
		.node_b         (edges.node_b),
		.cmd            (cmd),
		.sts            (sts),
		.merged         (results.merged),
		.root_first     (results.root_first),
		.root_second    (results.root_second),
		.sets_remaining (results.sets_remaining),
		.all_joined     (results.all_joined),
		.bad_index      (results.bad_index)
	);

endmodule

@@ rtl/dseu_dp.sv @@
// Datapath: parent memory, walk registers, set counter and result register.
// Depends on dseu_pkg; driven by commands from dseu_ctrl.
module dseu_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dseu_pkg::CNT_W-1:0] cfg_wdata,
	input  logic [dseu_pkg::IDX_W-1:0] node_a,
	input  logic [dseu_pkg::IDX_W-1:0] node_b,
	input  dseu_pkg::dseu_cmd_t       cmd,
	output dseu_pkg::dseu_sts_t       sts,
	output logic                      merged,
	output logic [dseu_pkg::IDX_W-1:0] root_first,
	output logic [dseu_pkg::IDX_W-1:0] root_second,
	output logic [dseu_pkg::CNT_W-1:0] sets_remaining,
	output logic                      all_joined,
	output logic                      bad_index
);
	import dseu_pkg::*;

	logic [IDX_W-1:0] mem [MAX_NODES];

	logic [IDX_W-1:0] a_q, b_q, root_q, cur_q, ra_q, rb_q, rdata_q, clr_cnt_q;
	logic [CNT_W-1:0] node_count_q, set_count_q, cfg_sat;
	logic             bad_q, merged_q;
	logic [IDX_W-1:0] start, raddr, waddr, wdata;
	logic             we;

	logic             res_merged_q, res_all_joined_q, res_bad_q;
	logic [IDX_W-1:0] res_ra_q, res_rb_q;
	logic [CNT_W-1:0] res_sets_q;

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_sat = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(MAX_NODES)) begin
			cfg_sat = CNT_W'(MAX_NODES);
		end else begin
			cfg_sat = cfg_wdata;
		end
	end

	assign start = cmd.phase_b ? b_q : a_q;

	assign sts.clr_last      = (clr_cnt_q == IDX_W'(MAX_NODES - 1));
	assign sts.bad           = bad_q;
	assign sts.rd_is_root    = (rdata_q == root_q);
	assign sts.start_is_root = (start == root_q);
	assign sts.roots_differ  = (ra_q != rb_q);

	// The read port follows the walk: the start node on an init step, and the
	// parent just returned on a walk step.
	always_comb begin
		raddr = start;
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = clr_cnt_q;
		case (cmd.op)
			OP_FIND_STEP, OP_COMP_STEP: begin
				raddr = rdata_q;
			end
			default: begin
				raddr = start;
			end
		endcase
		case (cmd.op)
			OP_CLEAR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = clr_cnt_q;
			end
			OP_COMP_STEP: begin
				we    = 1'b1;
				waddr = cur_q;
				wdata = root_q;
			end
			OP_LINK: begin
				we    = sts.roots_differ;
				waddr = ra_q;
				wdata = rb_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(MAX_NODES);
			set_count_q  <= CNT_W'(MAX_NODES);
			clr_cnt_q    <= '0;
		end else if (cfg_we) begin
			node_count_q <= cfg_sat;
			set_count_q  <= cfg_sat;
			clr_cnt_q    <= '0;
		end else begin
			if (cmd.op == OP_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end
			if (cmd.op == OP_LINK && sts.roots_differ && set_count_q > CNT_W'(1)) begin
				set_count_q <= set_count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				a_q      <= node_a;
				b_q      <= node_b;
				bad_q    <= ({1'b0, node_a} >= node_count_q) ||
				            ({1'b0, node_b} >= node_count_q);
				ra_q     <= '0;
				rb_q     <= '0;
				merged_q <= 1'b0;
			end
			OP_FIND_INIT: begin
				root_q <= start;
			end
			OP_FIND_STEP: begin
				if (!sts.rd_is_root) begin
					root_q <= rdata_q;
				end
			end
			OP_COMP_INIT: begin
				cur_q <= start;
				if (cmd.phase_b) begin
					rb_q <= root_q;
				end else begin
					ra_q <= root_q;
				end
			end
			OP_COMP_STEP: begin
				cur_q <= rdata_q;
			end
			OP_LINK: begin
				merged_q <= sts.roots_differ;
			end
			OP_RESULT: begin
				res_merged_q     <= merged_q;
				res_ra_q         <= ra_q;
				res_rb_q         <= rb_q;
				res_sets_q       <= set_count_q;
				res_all_joined_q <= (set_count_q == CNT_W'(1));
				res_bad_q        <= bad_q;
			end
			default: begin
			end
		endcase
	end

	assign merged         = res_merged_q;
	assign root_first     = res_ra_q;
	assign root_second    = res_rb_q;
	assign sets_remaining = res_sets_q;
	assign all_joined     = res_all_joined_q;
	assign bad_index      = res_bad_q;

endmodule

@@ rtl/dseu_ctrl.sv @@
// Controller: sequences the clearing pass, both root walks with compression,
// the link and the result hand-off. Depends on dseu_pkg.
module dseu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  dseu_pkg::dseu_sts_t sts,
	output dseu_pkg::dseu_cmd_t cmd
);
	import dseu_pkg::*;

	dseu_state_t state_q, state_d;
	logic        phase_q, phase_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cmd.op      = OP_NONE;
		cmd.phase_b = phase_q;
		in_ready    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.bad) begin
					state_d = ST_FINISH;
				end else begin
					phase_d = 1'b0;
					state_d = ST_FIND_INIT;
				end
			end
			ST_FIND_INIT: begin
				cmd.op  = OP_FIND_INIT;
				state_d = ST_FIND;
			end
			ST_FIND: begin
				cmd.op = OP_FIND_STEP;
				if (sts.rd_is_root) begin
					state_d = ST_COMP_INIT;
				end
			end
			ST_COMP_INIT: begin
				cmd.op = OP_COMP_INIT;
				if (sts.start_is_root) begin
					if (phase_q) begin
						state_d = ST_LINK;
					end else begin
						phase_d = 1'b1;
						state_d = ST_FIND_INIT;
					end
				end else begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.op = OP_COMP_STEP;
				if (sts.rd_is_root) begin
					if (phase_q) begin
						state_d = ST_LINK;
					end else begin
						phase_d = 1'b1;
						state_d = ST_FIND_INIT;
					end
				end
			end
			ST_LINK: begin
				cmd.op  = OP_LINK;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		// A node count write restarts the clearing pass of the parent memory.
		if (cfg_we) begin
			state_d = ST_CLEAR;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/dseu_checker.sv @@
// Port-level checks on the result channel of disjoint_set_edge_union.
// Depends on dseu_pkg; attached to the top level by the bind at the end.
module dseu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       merged,
	input logic [dseu_pkg::IDX_W-1:0] root_first,
	input logic [dseu_pkg::IDX_W-1:0] root_second,
	input logic [dseu_pkg::CNT_W-1:0] sets_remaining,
	input logic                       all_joined,
	input logic                       bad_index
);
	import dseu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_first) &&
		$stable(root_second) && $stable(sets_remaining) && $stable(merged))
		else $error("result word changed while stalled");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> !merged && root_first == '0 && root_second == '0)
		else $error("ignored edge reports a join or roots");

	a_merge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && merged |-> root_first != root_second)
		else $error("join reported with equal roots");

	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !merged && !bad_index |-> root_first == root_second)
		else $error("differing roots left unjoined");

	a_joined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> all_joined == (sets_remaining == CNT_W'(1)))
		else $error("all_joined disagrees with set count");

endmodule

bind disjoint_set_edge_union dseu_checker u_dseu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.merged         (results.merged),
	.root_first     (results.root_first),
	.root_second    (results.root_second),
	.sets_remaining (results.sets_remaining),
	.all_joined     (results.all_joined),
	.bad_index      (results.bad_index)
);
